/* hw/rtl/apbl_pkg.sv */
// ----------------------------------------------------------------------------
// apbl_pkg
// Shared types, codes and helpers of the attention position bias lookup.
// ----------------------------------------------------------------------------
package apbl_pkg;

   // default table limits
   localparam int DEF_MAX_WINDOW = 8;
   localparam int DEF_MAX_HEADS  = 16;
   localparam int DEF_MAX_SEQ    = 4096;

   // relative index span per head in the bias table
   localparam int REL_SPAN = 256;

   // command queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

   // request types
   localparam logic [1:0] REQ_WR_BIAS  = 2'd0;
   localparam logic [1:0] REQ_WR_INDEX = 2'd1;
   localparam logic [1:0] REQ_WR_SLOPE = 2'd2;
   localparam logic [1:0] REQ_QUERY    = 2'd3;

   // mode register codes
   localparam logic [1:0] MODE_COMPUTED = 2'd0;
   localparam logic [1:0] MODE_TABLE    = 2'd1;
   localparam logic [1:0] MODE_ALIBI    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MODE        = 2'd0;
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [1:0] CSR_HEAD_COUNT  = 2'd2;
   localparam logic [1:0] CSR_SEQ_LEN     = 2'd3;

   // register reset values
   localparam logic [1:0]  RST_MODE        = MODE_COMPUTED;
   localparam logic [3:0]  RST_WINDOW_SIZE = 4'd7;
   localparam logic [4:0]  RST_HEAD_COUNT  = 5'd8;
   localparam logic [12:0] RST_SEQ_LEN     = 13'd4096;

   typedef logic [2:0] op_type;

   // classified operations carried through the queue
   localparam op_type OP_NOP       = 3'd0;
   localparam op_type OP_WR_BIAS   = 3'd1;
   localparam op_type OP_WR_INDEX  = 3'd2;
   localparam op_type OP_WR_SLOPE  = 3'd3;
   localparam op_type OP_Q_DIRECT  = 3'd4;
   localparam op_type OP_Q_INDEXED = 3'd5;
   localparam op_type OP_Q_ALIBI   = 3'd6;
   localparam op_type OP_Q_OOR     = 3'd7;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  window_size;
      logic [4:0]  head_count;
      logic [12:0] seq_len;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  head;
      logic [11:0] qpos;
      logic [11:0] kpos;
      logic [7:0]  rel;
      logic [31:0] data;
   } q_entry_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic is_query(input op_type op);
      return (op == OP_Q_DIRECT) || (op == OP_Q_INDEXED) ||
             (op == OP_Q_ALIBI) || (op == OP_Q_OOR);
   endfunction

endpackage

/* hw/rtl/apbl_req_if.sv */
// ----------------------------------------------------------------------------
// apbl_req_if
// Request channel: table writes and bias queries, valid/ready handshake.
// ----------------------------------------------------------------------------
interface apbl_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [3:0]         head;
   logic [11:0]        query_pos;
   logic [11:0]        key_pos;
   logic [7:0]         rel_pos;
   logic signed [31:0] bias_in;
   logic [15:0]        slope_in;

   modport source (
      output valid, req_type, head, query_pos, key_pos, rel_pos, bias_in, slope_in,
      input  ready
   );

   modport sink (
      input  valid, req_type, head, query_pos, key_pos, rel_pos, bias_in, slope_in,
      output ready
   );
endinterface

/* hw/rtl/apbl_rsp_if.sv */
// ----------------------------------------------------------------------------
// apbl_rsp_if
// Response channel: one bias beat per query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface apbl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] bias_out;
   logic               out_of_range;

   modport source (
      output valid, bias_out, out_of_range,
      input  ready
   );

   modport sink (
      input  valid, bias_out, out_of_range,
      output ready
   );
endinterface

/* hw/rtl/apbl_ram.sv */
// ----------------------------------------------------------------------------
// apbl_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module apbl_ram
   import apbl_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [addr_bits(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]            wdata,
   input  logic                        re,
   input  logic [addr_bits(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/apbl_front.sv */
// ----------------------------------------------------------------------------
// apbl_front
// Accepts request beats, checks ranges, splits positions into row and column
// and forms the computed relative index; pushes classified commands.
// ----------------------------------------------------------------------------
module apbl_front
   import apbl_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int MAX_HEADS  = DEF_MAX_HEADS,
   parameter int MAX_SEQ    = DEF_MAX_SEQ
) (
   input  logic           clock,
   input  logic           reset,
   apbl_req_if.sink       req,
   input  cfg_type        cfg,
   input  logic [QCW-1:0] q_count,
   output logic           push,
   output q_entry_type    push_entry
);

   localparam int QB       = $clog2(MAX_WINDOW);
   localparam int PW       = 2 * QB;
   localparam int PW1      = PW + 1;
   localparam int DW       = $clog2(2 * MAX_WINDOW);
   localparam int RW       = 2 * DW;
   localparam int RCW      = (RW > 9) ? RW : 9;
   localparam int OCW      = QCW + 1;
   localparam int WIN_AREA = MAX_WINDOW * MAX_WINDOW;

   localparam logic [6:0]   HEAD_LIM = 7'(MAX_HEADS);
   localparam logic [16:0]  SEQ_LIM  = 17'(MAX_SEQ);
   localparam logic [12:0]  AREA_LIM = 13'(WIN_AREA);
   localparam logic [4:0]   WIN_LIM  = 5'(MAX_WINDOW);

   // restoring division of a window position by w, quotient and remainder
   function automatic logic [2*QB-1:0] div_w(input logic [PW-1:0] num,
                                              input logic [3:0] w);
      logic [PW:0]   rem;
      logic [PW:0]   dsr;
      logic [QB-1:0] q;
      rem = {1'b0, num};
      q   = '0;
      for (int b = QB - 1; b >= 0; b--) begin
         dsr = PW1'(w) << b;
         if (rem >= dsr) begin
            rem  = rem - dsr;
            q[b] = 1'b1;
         end
      end
      return {q, rem[QB-1:0]};
   endfunction

   // stage 1
   logic              accept;
   logic [7:0]        ww;
   logic              head_ok;
   logic              head_wr_ok;
   logic              win_ok;
   logic              seq_ok;
   logic              area_ok;
   op_type            op1_in;
   q_entry_type       e1_in;
   logic [2*QB-1:0]   idiv;
   logic [2*QB-1:0]   jdiv;
   logic [OCW-1:0]    occupancy;

   logic              f1_v_ff;
   q_entry_type       f1_entry_ff;
   logic [QB-1:0]     f1_ir_ff, f1_ic_ff, f1_jr_ff, f1_jc_ff;
   logic [DW-1:0]     f1_wm1_ff, f1_w2m1_ff;

   // stage 2
   logic [DW-1:0]     row_term;
   logic [DW-1:0]     col_term;
   logic [RW-1:0]     rel_full;
   logic              rel_ok;
   q_entry_type       e2_in;

   logic              f2_v_ff;
   q_entry_type       f2_entry_ff;

   // credit: everything in flight must fit in the queue
   assign occupancy = OCW'(q_count) + OCW'(f1_v_ff) + OCW'(f2_v_ff);
   assign req.ready = (occupancy < OCW'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;

   assign ww         = 8'(cfg.window_size) * 8'(cfg.window_size);
   assign head_ok    = (5'(req.head) < cfg.head_count) && (7'(req.head) < HEAD_LIM);
   assign head_wr_ok = (7'(req.head) < HEAD_LIM);
   assign win_ok     = (cfg.window_size != 4'd0) && (5'(cfg.window_size) <= WIN_LIM) &&
                       (req.query_pos < 12'(ww)) && (req.key_pos < 12'(ww));
   assign seq_ok     = (17'(req.query_pos) < 17'(cfg.seq_len)) &&
                       (17'(req.key_pos) < 17'(cfg.seq_len)) &&
                       (17'(req.query_pos) < SEQ_LIM) && (17'(req.key_pos) < SEQ_LIM);
   assign area_ok    = (13'(req.query_pos) < AREA_LIM) && (13'(req.key_pos) < AREA_LIM);

   assign idiv = div_w(req.query_pos[PW-1:0], cfg.window_size);
   assign jdiv = div_w(req.key_pos[PW-1:0], cfg.window_size);

   always_comb begin
      op1_in = OP_NOP;
      case (req.req_type)
         REQ_WR_BIAS:  op1_in = head_wr_ok ? OP_WR_BIAS : OP_NOP;
         REQ_WR_INDEX: op1_in = area_ok ? OP_WR_INDEX : OP_NOP;
         REQ_WR_SLOPE: op1_in = head_wr_ok ? OP_WR_SLOPE : OP_NOP;
         REQ_QUERY: begin
            if (!head_ok) begin
               op1_in = OP_Q_OOR;
            end else begin
               case (cfg.mode)
                  MODE_COMPUTED: op1_in = win_ok ? OP_Q_DIRECT : OP_Q_OOR;
                  MODE_TABLE:    op1_in = win_ok ? OP_Q_INDEXED : OP_Q_OOR;
                  MODE_ALIBI:    op1_in = seq_ok ? OP_Q_ALIBI : OP_Q_OOR;
                  default:       op1_in = OP_Q_OOR;
               endcase
            end
         end
         default: op1_in = OP_NOP;
      endcase
   end

   always_comb begin
      e1_in.op   = op1_in;
      e1_in.head = req.head;
      e1_in.qpos = req.query_pos;
      e1_in.kpos = req.key_pos;
      e1_in.rel  = req.rel_pos;
      e1_in.data = (req.req_type == REQ_WR_SLOPE) ? {16'h0000, req.slope_in}
                                                   : $unsigned(req.bias_in);
   end

   // ignored writes are dropped here
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= accept && (op1_in != OP_NOP);
      end
   end

   always_ff @(posedge clock) begin
      f1_entry_ff <= e1_in;
      f1_ir_ff    <= idiv[2*QB-1:QB];
      f1_ic_ff    <= idiv[QB-1:0];
      f1_jr_ff    <= jdiv[2*QB-1:QB];
      f1_jc_ff    <= jdiv[QB-1:0];
      f1_wm1_ff   <= DW'(cfg.window_size) - DW'(1);
      f1_w2m1_ff  <= DW'({cfg.window_size, 1'b0}) - DW'(1);
   end

   // (ir - jr + w - 1) * (2w - 1) + (ic - jc + w - 1)
   assign row_term = DW'(f1_ir_ff) + f1_wm1_ff - DW'(f1_jr_ff);
   assign col_term = DW'(f1_ic_ff) + f1_wm1_ff - DW'(f1_jc_ff);
   assign rel_full = RW'(row_term) * RW'(f1_w2m1_ff) + RW'(col_term);
   assign rel_ok   = (RCW'(rel_full) < RCW'(REL_SPAN));

   always_comb begin
      e2_in = f1_entry_ff;
      if (f1_entry_ff.op == OP_Q_DIRECT) begin
         e2_in.rel = 8'(rel_full);
         if (!rel_ok) begin
            e2_in.op = OP_Q_OOR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else begin
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      f2_entry_ff <= e2_in;
   end

   assign push       = f2_v_ff;
   assign push_entry = f2_entry_ff;

endmodule

/* hw/rtl/apbl_queue.sv */
// ----------------------------------------------------------------------------
// apbl_queue
// Short command queue that decouples the front from the table back end.
// ----------------------------------------------------------------------------
module apbl_queue
   import apbl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  q_entry_type    push_entry,
   input  logic           pop,
   output q_entry_type    head_entry,
   output logic [QCW-1:0] count
);

   localparam int QPW = $clog2(QUEUE_DEPTH);

   q_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff;
   logic [QPW-1:0] rd_ptr_ff;
   logic [QCW-1:0] count_ff;
   logic [QCW-1:0] count_in;

   assign count_in = count_ff + QCW'(push) - QCW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

/* hw/rtl/apbl_back.sv */
// ----------------------------------------------------------------------------
// apbl_back
// Executes queued commands against the index, slope and bias tables and
// forms the ALiBi product; holds the response beat in an output register.
// ----------------------------------------------------------------------------
module apbl_back
   import apbl_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int MAX_HEADS  = DEF_MAX_HEADS
) (
   input  logic           clock,
   input  logic           reset,
   input  q_entry_type    head_entry,
   input  logic [QCW-1:0] q_count,
   output logic           pop,
   apbl_rsp_if.source     rsp
);

   localparam int WIN_AREA   = MAX_WINDOW * MAX_WINDOW;
   localparam int IDX_DEPTH  = WIN_AREA * WIN_AREA;
   localparam int IAW        = addr_bits(IDX_DEPTH);
   localparam int BIAS_DEPTH = MAX_HEADS * REL_SPAN;
   localparam int BAW        = addr_bits(BIAS_DEPTH);
   localparam int SAW        = addr_bits(MAX_HEADS);

   logic               adv;

   // pop stage: index and slope tables
   logic [IAW-1:0]     idx_addr;
   logic [SAW-1:0]     slope_addr;
   logic [7:0]         idx_rdata;
   logic [15:0]        slope_rdata;
   logic signed [12:0] diff_in;

   logic               s1_v_ff;
   q_entry_type        s1_entry_ff;
   logic signed [12:0] s1_diff_ff;

   // stage 1: bias table and product
   logic [7:0]         rel_sel;
   logic [BAW-1:0]     bias_addr;
   logic [31:0]        bias_rdata;
   logic signed [29:0] slope_ext;
   logic signed [29:0] diff_ext;
   logic signed [29:0] prod_in;

   logic               s2_v_ff;
   op_type             s2_op_ff;
   logic signed [29:0] prod_ff;

   // output register
   logic               rsp_v_ff;
   logic signed [31:0] bias_out_ff;
   logic               oor_ff;
   logic signed [31:0] bias_out_in;

   assign adv = !rsp_v_ff || rsp.ready;
   assign pop = adv && (q_count != '0);

   assign idx_addr   = IAW'(32'(head_entry.qpos) * 32'(WIN_AREA) + 32'(head_entry.kpos));
   assign slope_addr = SAW'(head_entry.head);
   assign diff_in    = $signed({1'b0, head_entry.kpos}) - $signed({1'b0, head_entry.qpos});

   apbl_ram #(
      .WIDTH (8),
      .DEPTH (IDX_DEPTH)
   ) u_index_ram (
      .clock (clock),
      .we    (pop && (head_entry.op == OP_WR_INDEX)),
      .waddr (idx_addr),
      .wdata (head_entry.rel),
      .re    (pop && (head_entry.op == OP_Q_INDEXED)),
      .raddr (idx_addr),
      .rdata (idx_rdata)
   );

   apbl_ram #(
      .WIDTH (16),
      .DEPTH (MAX_HEADS)
   ) u_slope_ram (
      .clock (clock),
      .we    (pop && (head_entry.op == OP_WR_SLOPE)),
      .waddr (slope_addr),
      .wdata (head_entry.data[15:0]),
      .re    (pop && (head_entry.op == OP_Q_ALIBI)),
      .raddr (slope_addr),
      .rdata (slope_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_entry_ff <= head_entry;
         s1_diff_ff  <= diff_in;
      end
   end

   // learned table index comes from the index table or was computed up front
   assign rel_sel   = (s1_entry_ff.op == OP_Q_INDEXED) ? idx_rdata : s1_entry_ff.rel;
   assign bias_addr = BAW'({s1_entry_ff.head, rel_sel});

   apbl_ram #(
      .WIDTH (32),
      .DEPTH (BIAS_DEPTH)
   ) u_bias_ram (
      .clock (clock),
      .we    (adv && s1_v_ff && (s1_entry_ff.op == OP_WR_BIAS)),
      .waddr (bias_addr),
      .wdata (s1_entry_ff.data),
      .re    (adv && s1_v_ff && ((s1_entry_ff.op == OP_Q_DIRECT) ||
                                 (s1_entry_ff.op == OP_Q_INDEXED))),
      .raddr (bias_addr),
      .rdata (bias_rdata)
   );

   // slope is at most 16 bits and j - i at most 13, so the product never saturates
   assign slope_ext = 30'($signed({1'b0, slope_rdata}));
   assign diff_ext  = 30'(s1_diff_ff);
   assign prod_in   = slope_ext * diff_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_op_ff <= s1_entry_ff.op;
         prod_ff  <= prod_in;
      end
   end

   always_comb begin
      case (s2_op_ff)
         OP_Q_ALIBI:   bias_out_in = 32'(prod_ff);
         OP_Q_DIRECT:  bias_out_in = $signed(bias_rdata);
         OP_Q_INDEXED: bias_out_in = $signed(bias_rdata);
         default:      bias_out_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= s2_v_ff && is_query(s2_op_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bias_out_ff <= bias_out_in;
         oor_ff      <= (s2_op_ff == OP_Q_OOR);
      end
   end

   assign rsp.valid        = rsp_v_ff;
   assign rsp.bias_out     = bias_out_ff;
   assign rsp.out_of_range = oor_ff;

endmodule

/* hw/rtl/attention_position_bias_lookup.sv */
// ----------------------------------------------------------------------------
// attention_position_bias_lookup
// Attention bias per (head, query position, key position): learned table with
// computed or table-driven relative index, or ALiBi slope times distance.
// ----------------------------------------------------------------------------
// Usage
//   req_chan carries write beats (bias, index and slope tables) and query
//   beats; rsp_chan returns one beat per query and nothing for writes, in
//   request order. csr_* writes mode, window size, head count and sequence
//   length; write them only while no request is in flight.
//   A query passes through two front stages, the queue, two table stages
//   and the output register before its response is valid.
//   Throughput: one beat per cycle sustained while rsp_chan is ready; the back
//   end takes one queue entry per cycle; no table is touched twice per entry.
//   When rsp_chan stalls, the back end holds and the front keeps accepting
//   until the queue plus the two front stages hold four commands, then
//   req_chan.ready drops.
//   Reset restores the register defaults and empties the pipeline; table
//   contents are undefined until written, no clearing pass.
//   Out of range heads or positions answer zero with out_of_range set.
// ----------------------------------------------------------------------------
module attention_position_bias_lookup
   import apbl_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int MAX_HEADS  = DEF_MAX_HEADS,
   parameter int MAX_SEQ    = DEF_MAX_SEQ
) (
   input  logic        clock,
   input  logic        reset,
   apbl_req_if.sink    req_chan,
   apbl_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   logic [1:0]     mode_ff;
   logic [3:0]     window_size_ff;
   logic [4:0]     head_count_ff;
   logic [12:0]    seq_len_ff;
   cfg_type        cfg;

   logic           push;
   q_entry_type    push_entry;
   logic           pop;
   q_entry_type    head_entry;
   logic [QCW-1:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= RST_MODE;
         window_size_ff <= RST_WINDOW_SIZE;
         head_count_ff  <= RST_HEAD_COUNT;
         seq_len_ff     <= RST_SEQ_LEN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:        mode_ff        <= csr_wdata[1:0];
            CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[3:0];
            CSR_HEAD_COUNT:  head_count_ff  <= csr_wdata[4:0];
            CSR_SEQ_LEN:     seq_len_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode        = mode_ff;
   assign cfg.window_size = window_size_ff;
   assign cfg.head_count  = head_count_ff;
   assign cfg.seq_len     = seq_len_ff;

   apbl_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_HEADS  (MAX_HEADS),
      .MAX_SEQ    (MAX_SEQ)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg),
      .q_count    (q_count),
      .push       (push),
      .push_entry (push_entry)
   );

   apbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .count      (q_count)
   );

   apbl_back #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_HEADS  (MAX_HEADS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_count    (q_count),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

   // credit scheme must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      push |-> (q_count < QCW'(QUEUE_DEPTH)))
      else $error("command pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_count != '0))
      else $error("command popped from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (q_count == QCW'(QUEUE_DEPTH)) |-> !req_chan.ready)
      else $error("request accepted while queue is full");

endmodule

/* bench/attention_position_bias_lookup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attention_position_bias_lookup_tb
// Drives table writes and bias queries through the request channel, mirrors
// the three tables and the registers in a scoreboard, and compares every
// response beat in order. Both channels idle at random; registers change
// only between phases once the block has drained.
// ----------------------------------------------------------------------------
module attention_position_bias_lookup_tb
   import apbl_pkg::*;
;
   localparam int MAX_WIN     = DEF_MAX_WINDOW;
   localparam int WIN_AREA    = MAX_WIN * MAX_WIN;
   localparam int INDEX_DEPTH = WIN_AREA * WIN_AREA;
   localparam int BIAS_DEPTH  = DEF_MAX_HEADS * REL_SPAN;
   localparam int LIMIT       = 400000;

   // the register allows this code, it answers every query out of range
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         kind;
      logic [3:0]         head;
      logic [11:0]        qpos;
      logic [11:0]        kpos;
      logic [7:0]         rel;
      logic signed [31:0] bias;
      logic [15:0]        slope;
   } beat_type;

   typedef struct {
      logic signed [31:0] bias;
      logic               oor;
   } bias_result_type;

   class bias_mirror;
      logic [1:0]         mode;
      logic [3:0]         window;
      logic [4:0]         heads;
      logic [12:0]        seq;
      logic signed [31:0] bias_tab [BIAS_DEPTH];
      logic [7:0]         index_tab [INDEX_DEPTH];
      logic [15:0]        slope_tab [DEF_MAX_HEADS];
      bias_result_type    pending [$];
      int                 mismatches;
      int                 flagged;

      function new();
         mode       = RST_MODE;
         window     = RST_WINDOW_SIZE;
         heads      = RST_HEAD_COUNT;
         seq        = RST_SEQ_LEN;
         mismatches = 0;
         flagged    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [12:0] data);
         case (idx)
            CSR_MODE:        mode   = data[1:0];
            CSR_WINDOW_SIZE: window = data[3:0];
            CSR_HEAD_COUNT:  heads  = data[4:0];
            CSR_SEQ_LEN:     seq    = data;
            default: ;
         endcase
      endfunction

      // in range check; addr is the bias entry (computed), the index entry
      // (table) or the head (alibi) that the query reads
      function bit route(logic [3:0] head, logic [11:0] i, logic [11:0] j,
                         output int unsigned addr);
         int unsigned w;
         int unsigned lim;
         int unsigned rel;
         addr = 0;
         if (head >= heads || head >= DEF_MAX_HEADS) return 1'b0;
         case (mode)
            MODE_COMPUTED, MODE_TABLE: begin
               w = window;
               if (w == 0 || w > MAX_WIN || i >= w * w || j >= w * w) return 1'b0;
               if (mode == MODE_TABLE) begin
                  addr = i * WIN_AREA + j;
                  return 1'b1;
               end
               rel = (i / w + w - 1 - j / w) * (2 * w - 1) + (i % w + w - 1 - j % w);
               if (rel >= REL_SPAN) return 1'b0;
               addr = head * REL_SPAN + rel;
               return 1'b1;
            end
            MODE_ALIBI: begin
               lim = (seq < DEF_MAX_SEQ) ? seq : DEF_MAX_SEQ;
               if (i >= lim || j >= lim) return 1'b0;
               addr = head;
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function logic signed [31:0] alibi_bias(logic [15:0] slope, logic [11:0] i,
                                              logic [11:0] j);
         longint prod;
         prod = longint'(slope) * (longint'(j) - longint'(i));
         if (prod > 64'sd2147483647) prod = 64'sd2147483647;
         if (prod < -64'sd2147483648) prod = -64'sd2147483648;
         return prod[31:0];
      endfunction

      function void note_request(beat_type b);
         bias_result_type r;
         int unsigned     addr;
         case (b.kind)
            REQ_WR_BIAS:  bias_tab[{b.head, b.rel}] = b.bias;
            REQ_WR_INDEX: begin
               if (b.qpos < WIN_AREA && b.kpos < WIN_AREA)
                  index_tab[b.qpos * WIN_AREA + b.kpos] = b.rel;
            end
            REQ_WR_SLOPE: slope_tab[b.head] = b.slope;
            default: begin
               r.bias = '0;
               r.oor  = 1'b1;
               if (route(b.head, b.qpos, b.kpos, addr)) begin
                  r.oor = 1'b0;
                  case (mode)
                     MODE_COMPUTED: r.bias = bias_tab[addr];
                     MODE_TABLE:    r.bias = bias_tab[{b.head, index_tab[addr]}];
                     default:       r.bias = alibi_bias(slope_tab[b.head], b.qpos, b.kpos);
                  endcase
               end
               pending.push_back(r);
            end
         endcase
      endfunction

      function void check_response(logic signed [31:0] bias, logic oor);
         bias_result_type want;
         if (oor) flagged++;
         if (pending.size() == 0) begin
            $error("response beat with nothing pending: bias_out %0d out_of_range %0b",
                   bias, oor);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (bias !== want.bias) begin
            $error("bias_out: expected %0d, actual %0d", want.bias, bias);
            mismatches++;
         end
         if (oor !== want.oor) begin
            $error("out_of_range: expected %0b, actual %0b", want.oor, oor);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;

   apbl_req_if req ();
   apbl_rsp_if rsp ();

   attention_position_bias_lookup i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bias_mirror mirror;

   // what the stimulus has loaded so far, so no query reads an empty entry
   bit         bias_seen  [BIAS_DEPTH];
   bit         index_seen [INDEX_DEPTH];
   logic [7:0] index_val  [INDEX_DEPTH];
   bit         slope_seen [DEF_MAX_HEADS];

   bit quiet;
   int rsp_wait;
   int cycles;
   int n_queries;
   int n_writes;
   int settings;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      beat_type b;
      if (reset === 1'b0) begin
         if (req.valid && req.ready) begin
            b.kind  = req.req_type;
            b.head  = req.head;
            b.qpos  = req.query_pos;
            b.kpos  = req.key_pos;
            b.rel   = req.rel_pos;
            b.bias  = req.bias_in;
            b.slope = req.slope_in;
            mirror.note_request(b);
         end
         if (csr_we) mirror.write_reg(csr_index, csr_wdata);
      end
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 3);
   endfunction

   // response side: random stall before each beat
   initial begin
      rsp.ready <= 1'b0;
      rsp_wait = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0) begin
            if (rsp.valid && rsp.ready) begin
               mirror.check_response(rsp.bias_out, rsp.out_of_range);
               rsp_wait = draw_gap();
               rsp.ready <= (rsp_wait == 0);
            end else if (rsp_wait > 0) begin
               rsp.ready <= (rsp_wait == 1);
               rsp_wait = rsp_wait - 1;
            end else begin
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   function automatic beat_type random_beat(logic [1:0] kind);
      beat_type b;
      b.kind  = kind;
      b.head  = 4'($urandom);
      b.qpos  = 12'($urandom);
      b.kpos  = 12'($urandom);
      b.rel   = 8'($urandom);
      b.bias  = 32'($urandom);
      b.slope = 16'($urandom);
      return b;
   endfunction

   // valid stays high into the next beat when no gap is drawn
   task automatic send_beat(input beat_type b);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.req_type  <= b.kind;
      req.head      <= b.head;
      req.query_pos <= b.qpos;
      req.key_pos   <= b.kpos;
      req.rel_pos   <= b.rel;
      req.bias_in   <= b.bias;
      req.slope_in  <= b.slope;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      case (b.kind)
         REQ_WR_BIAS:  bias_seen[{b.head, b.rel}] = 1'b1;
         REQ_WR_INDEX: begin
            if (b.qpos < WIN_AREA && b.kpos < WIN_AREA) begin
               index_seen[b.qpos * WIN_AREA + b.kpos] = 1'b1;
               index_val[b.qpos * WIN_AREA + b.kpos]  = b.rel;
            end
         end
         REQ_WR_SLOPE: slope_seen[b.head] = 1'b1;
         default: ;
      endcase
      if (b.kind == REQ_QUERY) n_queries++;
      else n_writes++;
   endtask

   task automatic write_bias(input logic [3:0] head, input logic [7:0] rel,
                             input logic signed [31:0] value);
      beat_type b;
      b = random_beat(REQ_WR_BIAS);
      b.head = head;
      b.rel  = rel;
      b.bias = value;
      send_beat(b);
   endtask

   task automatic write_index(input logic [11:0] row, input logic [11:0] col,
                              input logic [7:0] value);
      beat_type b;
      b = random_beat(REQ_WR_INDEX);
      b.qpos = row;
      b.kpos = col;
      b.rel  = value;
      send_beat(b);
   endtask

   task automatic write_slope(input logic [3:0] head, input logic [15:0] value);
      beat_type b;
      b = random_beat(REQ_WR_SLOPE);
      b.head  = head;
      b.slope = value;
      send_beat(b);
   endtask

   // loads whatever entry the query will read before sending it
   task automatic query(input logic [3:0] head, input logic [11:0] i, input logic [11:0] j);
      beat_type    b;
      int unsigned addr;
      if (mirror.route(head, i, j, addr)) begin
         case (mirror.mode)
            MODE_COMPUTED: begin
               if (!bias_seen[addr]) write_bias(head, addr[7:0], 32'($urandom));
            end
            MODE_TABLE: begin
               if (!index_seen[addr]) write_index(i, j, 8'($urandom));
               if (!bias_seen[{head, index_val[addr]}])
                  write_bias(head, index_val[addr], 32'($urandom));
            end
            MODE_ALIBI: begin
               if (!slope_seen[head]) write_slope(head, 16'($urandom));
            end
            default: ;
         endcase
      end
      b = random_beat(REQ_QUERY);
      b.head = head;
      b.qpos = i;
      b.kpos = j;
      send_beat(b);
   endtask

   // wait for every pending response, then let queued writes retire
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (mirror.pending.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] idx, input logic [12:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic settle(input logic [1:0] m, input logic [3:0] w, input logic [4:0] hc,
                         input logic [12:0] sl);
      drain();
      put_reg(CSR_MODE, 13'(m));
      put_reg(CSR_WINDOW_SIZE, 13'(w));
      put_reg(CSR_HEAD_COUNT, 13'(hc));
      put_reg(CSR_SEQ_LEN, sl);
      csr_we <= 1'b0;
      @(posedge clock);
      settings++;
   endtask

   function automatic logic [3:0] random_head();
      int unsigned top;
      top = (mirror.heads > DEF_MAX_HEADS) ? DEF_MAX_HEADS : mirror.heads;
      if (top == 0 || $urandom_range(0, 7) == 0) return 4'($urandom);
      return 4'($urandom_range(0, top - 1));
   endfunction

   // mostly inside the current bounds, with edges and wild values mixed in
   function automatic logic [11:0] random_pos();
      int unsigned span;
      span = DEF_MAX_SEQ;
      if (mirror.mode == MODE_COMPUTED || mirror.mode == MODE_TABLE) begin
         if (mirror.window >= 1 && mirror.window <= MAX_WIN)
            span = mirror.window * mirror.window;
         else
            span = WIN_AREA;
      end else if (mirror.mode == MODE_ALIBI && mirror.seq != 0 && mirror.seq < DEF_MAX_SEQ) begin
         span = mirror.seq;
      end
      case ($urandom_range(0, 9))
         0: return 12'($urandom);
         1: return 12'(span - 1);
         2: return '0;
         default: return 12'($urandom_range(0, span - 1));
      endcase
   endfunction

   function automatic logic [11:0] table_pos();
      if ($urandom_range(0, 5) == 0) return 12'($urandom);
      return 12'($urandom_range(0, WIN_AREA - 1));
   endfunction

   task automatic run_phase(input logic [1:0] m, input logic [3:0] w, input logic [4:0] hc,
                            input logic [12:0] sl, input int count);
      int pick;
      settle(m, w, hc, sl);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 9) write_bias(4'($urandom), 8'($urandom), 32'($urandom));
         else if (pick < 16) write_index(table_pos(), table_pos(), 8'($urandom));
         else if (pick < 20) write_slope(4'($urandom), 16'($urandom));
         else if (pick == 20) drain();
         else query(random_head(), random_pos(), random_pos());
      end
   endtask

   initial begin
      mirror = new();
      quiet     = 1'b0;
      n_queries = 0;
      n_writes  = 0;
      settings  = 1;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.req_type  <= REQ_QUERY;
      req.head      <= '0;
      req.query_pos <= '0;
      req.key_pos   <= '0;
      req.rel_pos   <= '0;
      req.bias_in   <= '0;
      req.slope_in  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_MODE;
      csr_wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: computed index, 7 x 7 window, 8 heads
      write_bias(4'd0, 8'd0, 32'sh8000_0000);
      write_bias(4'd15, 8'd255, 32'sh7fff_ffff);
      query(4'd0, 12'd24, 12'd24);
      query(4'd0, 12'd0, 12'd48);
      query(4'd7, 12'd48, 12'd0);
      query(4'd8, 12'd0, 12'd0);
      query(4'd15, 12'd0, 12'd0);
      query(4'd0, 12'd49, 12'd0);
      query(4'd0, 12'd0, 12'd4095);
      // index writes off the table are dropped
      write_index(12'd64, 12'd0, 8'($urandom));
      write_index(12'd0, 12'd4095, 8'($urandom));
      write_slope(4'd0, 16'hffff);
      write_slope(4'd15, 16'h0000);

      settle(MODE_TABLE, 4'd8, 5'd16, 13'd4096);
      write_index(12'd63, 12'd63, 8'd255);
      query(4'd15, 12'd63, 12'd63);
      query(4'd3, 12'd0, 12'd0);

      settle(MODE_ALIBI, 4'd8, 5'd16, 13'd4096);
      query(4'd0, 12'd0, 12'd4095);
      query(4'd0, 12'd4095, 12'd0);
      query(4'd0, 12'd100, 12'd100);
      query(4'd15, 12'd7, 12'd3);

      settle(MODE_ALIBI, 4'd8, 5'd16, 13'd10);
      query(4'd0, 12'd10, 12'd0);
      query(4'd0, 12'd9, 12'd9);

      settle(MODE_UNUSED, 4'd7, 5'd8, 13'd4096);
      query(4'd0, 12'd0, 12'd0);

      run_phase(MODE_COMPUTED, 4'd7, 5'd8, 13'd4096, 90);
      run_phase(MODE_COMPUTED, 4'd1, 5'd16, 13'd4096, 40);
      run_phase(MODE_COMPUTED, 4'd8, 5'd31, 13'd4096, 80);
      run_phase(MODE_TABLE, 4'd8, 5'd16, 13'd4096, 80);
      run_phase(MODE_TABLE, 4'd3, 5'd5, 13'd4096, 40);
      run_phase(MODE_ALIBI, 4'd7, 5'd16, 13'd4096, 80);
      run_phase(MODE_ALIBI, 4'd7, 5'd1, 13'd1, 30);
      run_phase(MODE_ALIBI, 4'd2, 5'd12, 13'd8191, 40);
      run_phase(MODE_ALIBI, 4'd7, 5'd16, 13'd0, 10);
      run_phase(MODE_ALIBI, 4'd7, 5'd16, 13'd100, 30);
      run_phase(MODE_UNUSED, 4'd7, 5'd8, 13'd4096, 10);
      run_phase(MODE_COMPUTED, 4'd0, 5'd8, 13'd4096, 10);
      run_phase(MODE_TABLE, 4'd15, 5'd8, 13'd4096, 10);
      run_phase(MODE_COMPUTED, 4'd5, 5'd0, 13'd4096, 10);
      drain();

      $display("run covered %0d queries (%0d answered out of range) and %0d table writes",
               n_queries, mirror.flagged, n_writes);
      $display("across %0d register settings, all four mode codes included", settings);
      if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
